### src/gbs_pkg.sv
// Shared types and constants for the greedy box suppression block.
// No dependencies; used by gbs_ctrl, gbs_datapath and the top level.
`timescale 1ns / 1ps

package gbs_pkg;

    localparam int MAX_BOXES   = 64;
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 7;
    localparam int THR_W       = 17;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_DATA_W   = 144;
    localparam int OUT_DATA_W  = 16;

    localparam logic [THR_W-1:0] THR_RESET = 17'd29491;
    localparam logic [33:0]      ONE_PIXEL = 34'd65536;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_OFS = 8'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             area_en;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             int_en;
        logic             mul_en;
        logic             uni_en;
        logic             th0_en;
        logic             th1_en;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
    } status_t;

endpackage

### src/gbs_datapath.sv
// Datapath: input capture, kept-box memory and the shared overlap unit.
// Depends on gbs_pkg.
`timescale 1ns / 1ps

module gbs_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [gbs_pkg::IN_DATA_W-1:0] in_data,
    input  logic                          cfg_valid,
    input  logic [gbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  gbs_pkg::cmd_t                 cmd,
    output gbs_pkg::status_t              status
);

    logic [16:0] thr_reg;
    logic        ofs_mode_reg;

    logic signed [31:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [33:0] wd_reg, ht_reg;
    logic signed [63:0] area_reg;

    logic [191:0] mem [gbs_pkg::STORE_DEPTH];
    logic [191:0] rd_reg;

    logic [33:0]        iw_reg, ih_reg;
    logic [62:0]        inter_reg;
    logic               nonpos_reg;
    logic [63:0]        ulo_reg;
    logic [48:0]        p0_reg, p1_reg;

    logic signed [33:0] off;
    logic signed [67:0] area_prod;
    logic signed [31:0] k_x1, k_y1, k_x2, k_y2;
    logic signed [63:0] k_area;
    logic signed [31:0] ix1, iy1, ix2, iy2;
    logic signed [33:0] iw, ih;
    logic [67:0]        inter_prod;
    logic signed [65:0] union_sum;
    logic [80:0]        rhs;
    logic [80:0]        lhs;

    assign off = ofs_mode_reg ? $signed(gbs_pkg::ONE_PIXEL) : 34'sd0;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= gbs_pkg::THR_RESET;
            ofs_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == gbs_pkg::REG_THRESHOLD) begin
                thr_reg <= cfg_data[16:0];
            end else if (cfg_index == gbs_pkg::REG_PIXEL_OFS) begin
                ofs_mode_reg <= cfg_data[0];
            end
        end
    end

    // Capture of the incoming box and its width and height.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x1_reg <= in_data[31:0];
            y1_reg <= in_data[63:32];
            x2_reg <= in_data[95:64];
            y2_reg <= in_data[127:96];
            wd_reg <= 34'($signed(in_data[95:64])) - 34'($signed(in_data[31:0])) + off;
            ht_reg <= 34'($signed(in_data[127:96])) - 34'($signed(in_data[63:32])) + off;
        end
    end

    // Box area with signed saturation to 64 bits.
    assign area_prod = 68'(wd_reg) * 68'(ht_reg);

    always_ff @(posedge aclk) begin
        if (cmd.area_en) begin
            if (area_prod[67:63] == 5'b00000 || area_prod[67:63] == 5'b11111) begin
                area_reg <= area_prod[63:0];
            end else if (area_prod[67]) begin
                area_reg <= {1'b1, 63'd0};
            end else begin
                area_reg <= {1'b0, {63{1'b1}}};
            end
        end
    end

    // Kept-box memory: one word per kept box, registered read.
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= {area_reg, y2_reg, x2_reg, y1_reg, x1_reg};
        end
        if (cmd.rd_en) begin
            rd_reg <= mem[cmd.rd_addr];
        end
    end

    assign k_x1   = rd_reg[31:0];
    assign k_y1   = rd_reg[63:32];
    assign k_x2   = rd_reg[95:64];
    assign k_y2   = rd_reg[127:96];
    assign k_area = rd_reg[191:128];

    // Intersection edges, widths clamped at zero.
    assign ix1 = (k_x1 > x1_reg) ? k_x1 : x1_reg;
    assign iy1 = (k_y1 > y1_reg) ? k_y1 : y1_reg;
    assign ix2 = (k_x2 < x2_reg) ? k_x2 : x2_reg;
    assign iy2 = (k_y2 < y2_reg) ? k_y2 : y2_reg;
    assign iw  = 34'(ix2) - 34'(ix1) + off;
    assign ih  = 34'(iy2) - 34'(iy1) + off;

    always_ff @(posedge aclk) begin
        if (cmd.int_en) begin
            iw_reg <= iw[33] ? 34'd0 : iw;
            ih_reg <= ih[33] ? 34'd0 : ih;
        end
    end

    // Intersection area, saturated to the largest positive value.
    assign inter_prod = 68'(iw_reg) * 68'(ih_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            inter_reg <= (|inter_prod[67:63]) ? {63{1'b1}} : inter_prod[62:0];
        end
    end

    // Union, exact in 66 bits.
    assign union_sum = 66'(k_area) + 66'(area_reg) - $signed({3'b000, inter_reg});

    always_ff @(posedge aclk) begin
        if (cmd.uni_en) begin
            nonpos_reg <= union_sum[65] || (union_sum == 66'sd0);
            ulo_reg    <= union_sum[63:0];
        end
    end

    // Threshold times union, one 32-bit half per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.th0_en) begin
            p0_reg <= 49'(thr_reg) * 49'(ulo_reg[31:0]);
        end
        if (cmd.th1_en) begin
            p1_reg <= 49'(thr_reg) * 49'(ulo_reg[63:32]);
        end
    end

    assign rhs = 81'(p0_reg) + {p1_reg, 32'd0};
    assign lhs = {2'b00, inter_reg, 16'd0};

    // Suppression decision for the current kept box.
    assign status.hit = nonpos_reg ? (inter_reg != 63'd0) : (lhs > rhs);

endmodule

### src/gbs_ctrl.sv
// Controller: sequencer over the kept boxes, set counters and result word.
// Depends on gbs_pkg.
`timescale 1ns / 1ps

module gbs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   score_nonpos,
    input  logic                   last_in,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   out_kept,
    output logic [5:0]             out_pos,
    output logic [6:0]             out_total,
    output logic                   out_ovf,
    output logic                   out_done,
    output gbs_pkg::cmd_t          cmd,
    input  gbs_pkg::status_t       status
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_AREA  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_INT   = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_UNI   = 4'd5;
    localparam logic [3:0] ST_TH0   = 4'd6;
    localparam logic [3:0] ST_TH1   = 4'd7;
    localparam logic [3:0] ST_DEC   = 4'd8;
    localparam logic [3:0] ST_WRITE = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [6:0] kept_cnt_reg, kept_cnt_next;
    logic [6:0] arr_reg, arr_next;
    logic       stop_reg, stop_next;
    logic [5:0] idx_reg, idx_next;
    logic [6:0] pos_reg, pos_next;
    logic       ovf_reg, ovf_next;
    logic       last_reg, last_next;
    logic       kept_reg, kept_next;
    logic       mv_reg, mv_next;
    logic       ok_reg, ok_next;
    logic [5:0] opos_reg, opos_next;
    logic [6:0] otot_reg, otot_next;
    logic       oovf_reg, oovf_next;
    logic       odone_reg, odone_next;
    logic       accept;
    logic       new_stop;
    logic       new_ovf;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = mv_reg;
    assign out_kept  = ok_reg;
    assign out_pos   = opos_reg;
    assign out_total = otot_reg;
    assign out_ovf   = oovf_reg;
    assign out_done  = odone_reg;
    assign new_stop  = stop_reg || score_nonpos;
    assign new_ovf   = (arr_reg >= 7'(gbs_pkg::MAX_BOXES));

    // Next-state and command logic.
    always_comb begin
        state_next    = state_reg;
        kept_cnt_next = kept_cnt_reg;
        arr_next      = arr_reg;
        stop_next     = stop_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        ovf_next      = ovf_reg;
        last_next     = last_reg;
        kept_next     = kept_reg;
        mv_next       = mv_reg && !m_tready;
        ok_next       = ok_reg;
        opos_next     = opos_reg;
        otot_next     = otot_reg;
        oovf_next     = oovf_reg;
        odone_next    = odone_reg;
        cmd           = '0;
        cmd.rd_addr   = idx_reg;
        cmd.wr_addr   = kept_cnt_reg[5:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load  = 1'b1;
                    pos_next  = arr_reg;
                    ovf_next  = new_ovf;
                    stop_next = new_stop;
                    last_next = last_in;
                    kept_next = 1'b0;
                    idx_next  = 6'd0;
                    state_next = (new_ovf || new_stop) ? ST_FIN : ST_AREA;
                end
            end
            ST_AREA: begin
                cmd.area_en = 1'b1;
                state_next  = (kept_cnt_reg == 7'd0) ? ST_WRITE : ST_RD;
            end
            ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_INT;
            end
            ST_INT: begin
                cmd.int_en = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_UNI;
            end
            ST_UNI: begin
                cmd.uni_en = 1'b1;
                state_next = ST_TH0;
            end
            ST_TH0: begin
                cmd.th0_en = 1'b1;
                state_next = ST_TH1;
            end
            ST_TH1: begin
                cmd.th1_en = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                if (status.hit) begin
                    state_next = ST_FIN;
                end else if (7'(idx_reg) + 7'd1 == kept_cnt_reg) begin
                    state_next = ST_WRITE;
                end else begin
                    idx_next   = idx_reg + 6'd1;
                    state_next = ST_RD;
                end
            end
            ST_WRITE: begin
                cmd.wr_en     = 1'b1;
                kept_cnt_next = kept_cnt_reg + 7'd1;
                kept_next     = 1'b1;
                state_next    = ST_FIN;
            end
            ST_FIN: begin
                // Load the result word once the output register is free.
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    ok_next    = kept_reg;
                    opos_next  = (pos_reg > 7'd63) ? 6'd63 : pos_reg[5:0];
                    otot_next  = kept_cnt_reg;
                    oovf_next  = ovf_reg;
                    odone_next = last_reg;
                    if (last_reg) begin
                        kept_cnt_next = 7'd0;
                        arr_next      = 7'd0;
                        stop_next     = 1'b0;
                    end else if (arr_reg != 7'd127) begin
                        arr_next = arr_reg + 7'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kept_cnt_reg <= 7'd0;
            arr_reg      <= 7'd0;
            stop_reg     <= 1'b0;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            kept_cnt_reg <= kept_cnt_next;
            arr_reg      <= arr_next;
            stop_reg     <= stop_next;
            mv_reg       <= mv_next;
        end
    end

    // Per-item registers and result word.
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        ovf_reg   <= ovf_next;
        last_reg  <= last_next;
        kept_reg  <= kept_next;
        ok_reg    <= ok_next;
        opos_reg  <= opos_next;
        otot_reg  <= otot_next;
        oovf_reg  <= oovf_next;
        odone_reg <= odone_next;
    end

    // The kept store never exceeds its depth.
    a_kept_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_cnt_reg <= 7'(gbs_pkg::STORE_DEPTH))
        else $error("kept count beyond store depth");

    // A write into the store raises the kept count by one.
    a_write_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WRITE |=> kept_cnt_reg == $past(kept_cnt_reg) + 7'd1)
        else $error("kept count did not follow store write");

    // The sequencer only reads entries that hold a kept box.
    a_read_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD |-> 7'(idx_reg) < kept_cnt_reg)
        else $error("read beyond kept boxes");

endmodule

### src/greedy_box_suppression.sv
// Top level of the greedy box suppression block.
// Depends on gbs_pkg, gbs_ctrl and gbs_datapath.
//
//  channel | direction | word
//  s_      | in        | tdata: box_x1, box_y1, box_x2, box_y2, box_score; tlast: last_box
//  m_      | out       | tdata: is_kept, box_position, kept_total, set_overflow; tlast: set_done
//  cfg_    | in        | cfg_index selects the register, cfg_data carries its value
//
// A box that is dropped for score or overflow goes straight to its result. Every other box is
// tested against the kept boxes in turn until one suppresses it; a box that none of them
// suppresses is written into the store. One shared overlap unit works on one kept
// box at a time (read, clamp, intersection product, union, two threshold halves, decide).
// Reset is synchronous and active low; the kept store needs no clearing.
// A new word is accepted while the previous result waits in the output register;
// the block stalls before loading a new result while the held one waits and m_tready is low.
`timescale 1ns / 1ps

module greedy_box_suppression (
    input  logic                           aclk,
    input  logic                           aresetn,
    // box_x1[31:0], box_y1[63:32], box_x2[95:64], box_y2[127:96], box_score[143:128]
    input  logic [gbs_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // is_kept[0], box_position[6:1], kept_total[13:7], set_overflow[14], zero[15]
    output logic [gbs_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbs_pkg::CFG_DATA_W-1:0] cfg_data
);

    gbs_pkg::cmd_t    cmd;
    gbs_pkg::status_t status;
    logic             score_nonpos;
    logic             out_kept;
    logic [5:0]       out_pos;
    logic [6:0]       out_total;
    logic             out_ovf;

    assign cfg_ready    = 1'b1;
    assign score_nonpos = s_tdata[143] || (s_tdata[143:128] == 16'd0);
    assign m_tdata      = {1'b0, out_ovf, out_total, out_pos, out_kept};

    // Sequencer and counters.
    gbs_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .score_nonpos (score_nonpos),
        .last_in      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_kept     (out_kept),
        .out_pos      (out_pos),
        .out_total    (out_total),
        .out_ovf      (out_ovf),
        .out_done     (m_tlast),
        .cmd          (cmd),
        .status       (status)
    );

    // Store and overlap arithmetic.
    gbs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
